>>> src/srdz_pkg.sv
package srdz_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 15;
  localparam int OUT_BITS    = FRAC_BITS + 1;
  localparam int REG_BITS    = 16;
  localparam int LEN_FRAC    = 8;
  localparam int MAG_BITS    = SAMPLE_BITS;
  localparam int SQ_BITS     = 2 * MAG_BITS;
  localparam int RAD_BITS    = SQ_BITS + 2 * LEN_FRAC;
  localparam int LEN_BITS    = RAD_BITS / 2;
  localparam int SQRT_STAGES = LEN_BITS;
  localparam int FQ_STAGES   = FRAC_BITS;
  localparam int FQ_BITS     = FRAC_BITS + 1;
  localparam int PROD_BITS   = MAG_BITS + FQ_BITS;
  localparam int DVD_BITS    = PROD_BITS + LEN_FRAC + 1;
  localparam int CQ_STAGES   = FRAC_BITS + 2;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_DEAD_ZONE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_VALUE = 2'd1;

  localparam logic [REG_BITS-1:0] DEAD_ZONE_RESET = 16'd8000;
  localparam logic [REG_BITS-1:0] MAX_VALUE_RESET = 16'd30000;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] stick_x;
    logic signed [SAMPLE_BITS-1:0] stick_y;
  } sample_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] out_x;
    logic signed [OUT_BITS-1:0] out_y;
    logic                       in_dead_zone;
  } result_t;

  typedef struct packed {
    logic                nx;
    logic                ny;
    logic [MAG_BITS-1:0] ax;
    logic [MAG_BITS-1:0] ay;
    logic                dead;
  } side_t;

endpackage

>>> src/srdz_sqrt.sv
module srdz_sqrt (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_vld,
  input  srdz_pkg::side_t                 in_side,
  input  logic [srdz_pkg::SQ_BITS-1:0]    in_sq,
  output logic                            out_vld,
  output srdz_pkg::side_t                 out_side,
  output logic [srdz_pkg::LEN_BITS-1:0]   out_len
);
  import srdz_pkg::*;

  localparam int REM_BITS = LEN_BITS + 3;

  logic [REM_BITS-1:0] rem  [SQRT_STAGES];
  logic [LEN_BITS-1:0] root [SQRT_STAGES];
  logic [RAD_BITS-1:0] rad  [SQRT_STAGES];
  side_t               side [SQRT_STAGES];
  logic                vld  [SQRT_STAGES];

  logic [REM_BITS-1:0] rem_next  [SQRT_STAGES];
  logic [LEN_BITS-1:0] root_next [SQRT_STAGES];
  logic [RAD_BITS-1:0] rad_next  [SQRT_STAGES];

  always_comb begin
    logic [REM_BITS-1:0] prem;
    logic [LEN_BITS-1:0] proot;
    logic [RAD_BITS-1:0] prad;
    logic [REM_BITS-1:0] rw;
    logic [REM_BITS-1:0] trial;
    for (int i = 0; i < SQRT_STAGES; i++) begin
      if (i == 0) begin
        prem  = '0;
        proot = '0;
        prad  = {in_sq, {(2*LEN_FRAC){1'b0}}};
      end else begin
        prem  = rem[i-1];
        proot = root[i-1];
        prad  = rad[i-1];
      end
      rw    = {prem[REM_BITS-3:0], prad[RAD_BITS-1 -: 2]};
      trial = {1'b0, proot, 2'b01};
      if (rw >= trial) begin
        rem_next[i]  = rw - trial;
        root_next[i] = {proot[LEN_BITS-2:0], 1'b1};
      end else begin
        rem_next[i]  = rw;
        root_next[i] = {proot[LEN_BITS-2:0], 1'b0};
      end
      rad_next[i] = {prad[RAD_BITS-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SQRT_STAGES; i++) vld[i] <= 1'b0;
    end else if (en) begin
      for (int i = 0; i < SQRT_STAGES; i++) vld[i] <= (i == 0) ? in_vld : vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < SQRT_STAGES; i++) begin
        rem[i]  <= rem_next[i];
        root[i] <= root_next[i];
        rad[i]  <= rad_next[i];
        side[i] <= (i == 0) ? in_side : side[i-1];
      end
    end
  end

  assign out_vld  = vld[SQRT_STAGES-1];
  assign out_side = side[SQRT_STAGES-1];
  assign out_len  = root[SQRT_STAGES-1];

endmodule

>>> src/srdz_fdiv.sv
module srdz_fdiv (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_vld,
  input  srdz_pkg::side_t                 in_side,
  input  logic [srdz_pkg::LEN_BITS-1:0]   in_len,
  input  logic                            in_full,
  input  logic [srdz_pkg::LEN_BITS-1:0]   in_num,
  input  logic [srdz_pkg::LEN_BITS-1:0]   in_den,
  output logic                            out_vld,
  output srdz_pkg::side_t                 out_side,
  output logic [srdz_pkg::LEN_BITS-1:0]   out_len,
  output logic                            out_full,
  output logic [srdz_pkg::FRAC_BITS-1:0]  out_quo
);
  import srdz_pkg::*;

  localparam int REM_BITS = LEN_BITS + 1;

  logic [REM_BITS-1:0]  rem  [FQ_STAGES];
  logic [FRAC_BITS-1:0] quo  [FQ_STAGES];
  logic [LEN_BITS-1:0]  den  [FQ_STAGES];
  logic [LEN_BITS-1:0]  len  [FQ_STAGES];
  logic                 full [FQ_STAGES];
  side_t                side [FQ_STAGES];
  logic                 vld  [FQ_STAGES];

  logic [REM_BITS-1:0]  rem_next [FQ_STAGES];
  logic [FRAC_BITS-1:0] quo_next [FQ_STAGES];

  always_comb begin
    logic [REM_BITS-1:0]  prem;
    logic [FRAC_BITS-1:0] pquo;
    logic [LEN_BITS-1:0]  pden;
    logic [REM_BITS-1:0]  rw;
    for (int i = 0; i < FQ_STAGES; i++) begin
      if (i == 0) begin
        prem = {1'b0, in_num};
        pquo = '0;
        pden = in_den;
      end else begin
        prem = rem[i-1];
        pquo = quo[i-1];
        pden = den[i-1];
      end
      rw = {prem[REM_BITS-2:0], 1'b0};
      if (rw >= {1'b0, pden}) begin
        rem_next[i] = rw - {1'b0, pden};
        quo_next[i] = {pquo[FRAC_BITS-2:0], 1'b1};
      end else begin
        rem_next[i] = rw;
        quo_next[i] = {pquo[FRAC_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FQ_STAGES; i++) vld[i] <= 1'b0;
    end else if (en) begin
      for (int i = 0; i < FQ_STAGES; i++) vld[i] <= (i == 0) ? in_vld : vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < FQ_STAGES; i++) begin
        rem[i]  <= rem_next[i];
        quo[i]  <= quo_next[i];
        den[i]  <= (i == 0) ? in_den  : den[i-1];
        len[i]  <= (i == 0) ? in_len  : len[i-1];
        full[i] <= (i == 0) ? in_full : full[i-1];
        side[i] <= (i == 0) ? in_side : side[i-1];
      end
    end
  end

  assign out_vld  = vld[FQ_STAGES-1];
  assign out_side = side[FQ_STAGES-1];
  assign out_len  = len[FQ_STAGES-1];
  assign out_full = full[FQ_STAGES-1];
  assign out_quo  = quo[FQ_STAGES-1];

endmodule

>>> src/srdz_cdiv.sv
module srdz_cdiv (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_vld,
  input  srdz_pkg::side_t                 in_side,
  input  logic [srdz_pkg::LEN_BITS-1:0]   in_len,
  input  logic [srdz_pkg::DVD_BITS-1:0]   in_dx,
  input  logic [srdz_pkg::DVD_BITS-1:0]   in_dy,
  output logic                            out_vld,
  output srdz_pkg::side_t                 out_side,
  output logic [srdz_pkg::LEN_BITS-1:0]   out_len,
  output logic [srdz_pkg::CQ_STAGES-1:0]  out_qx,
  output logic [srdz_pkg::CQ_STAGES-1:0]  out_qy
);
  import srdz_pkg::*;

  localparam int REM_BITS = LEN_BITS + 1;
  localparam int HI_BITS  = DVD_BITS - CQ_STAGES;

  logic [REM_BITS-1:0]  rx   [CQ_STAGES];
  logic [REM_BITS-1:0]  ry   [CQ_STAGES];
  logic [CQ_STAGES-1:0] lx   [CQ_STAGES];
  logic [CQ_STAGES-1:0] ly   [CQ_STAGES];
  logic [LEN_BITS-1:0]  len  [CQ_STAGES];
  side_t                side [CQ_STAGES];
  logic                 vld  [CQ_STAGES];

  logic [REM_BITS-1:0]  rx_next [CQ_STAGES];
  logic [REM_BITS-1:0]  ry_next [CQ_STAGES];
  logic [CQ_STAGES-1:0] lx_next [CQ_STAGES];
  logic [CQ_STAGES-1:0] ly_next [CQ_STAGES];

  always_comb begin
    logic [REM_BITS-1:0]  prx, pry;
    logic [CQ_STAGES-1:0] plx, ply;
    logic [LEN_BITS-1:0]  plen;
    logic [REM_BITS-1:0]  wx, wy, dv;
    for (int i = 0; i < CQ_STAGES; i++) begin
      if (i == 0) begin
        prx  = REM_BITS'(in_dx[DVD_BITS-1 -: HI_BITS]);
        pry  = REM_BITS'(in_dy[DVD_BITS-1 -: HI_BITS]);
        plx  = in_dx[CQ_STAGES-1:0];
        ply  = in_dy[CQ_STAGES-1:0];
        plen = in_len;
      end else begin
        prx  = rx[i-1];
        pry  = ry[i-1];
        plx  = lx[i-1];
        ply  = ly[i-1];
        plen = len[i-1];
      end
      dv = {1'b0, plen};
      wx = {prx[REM_BITS-2:0], plx[CQ_STAGES-1]};
      wy = {pry[REM_BITS-2:0], ply[CQ_STAGES-1]};
      if (wx >= dv) begin
        rx_next[i] = wx - dv;
        lx_next[i] = {plx[CQ_STAGES-2:0], 1'b1};
      end else begin
        rx_next[i] = wx;
        lx_next[i] = {plx[CQ_STAGES-2:0], 1'b0};
      end
      if (wy >= dv) begin
        ry_next[i] = wy - dv;
        ly_next[i] = {ply[CQ_STAGES-2:0], 1'b1};
      end else begin
        ry_next[i] = wy;
        ly_next[i] = {ply[CQ_STAGES-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CQ_STAGES; i++) vld[i] <= 1'b0;
    end else if (en) begin
      for (int i = 0; i < CQ_STAGES; i++) vld[i] <= (i == 0) ? in_vld : vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < CQ_STAGES; i++) begin
        rx[i]   <= rx_next[i];
        ry[i]   <= ry_next[i];
        lx[i]   <= lx_next[i];
        ly[i]   <= ly_next[i];
        len[i]  <= (i == 0) ? in_len  : len[i-1];
        side[i] <= (i == 0) ? in_side : side[i-1];
      end
    end
  end

  assign out_vld  = vld[CQ_STAGES-1];
  assign out_side = side[CQ_STAGES-1];
  assign out_len  = len[CQ_STAGES-1];
  assign out_qx   = lx[CQ_STAGES-1];
  assign out_qy   = ly[CQ_STAGES-1];

endmodule

>>> src/stick_radial_dead_zone_core.sv
// Radial dead zone for one analog stick sample per request.
// Input channel: in_valid/in_ready with in_data (stick_x, stick_y, signed).
// Output channel: out_valid/out_ready with out_data (out_x, out_y in signed
// Q1.15, in_dead_zone flag).
// Config channel: cfg_valid/cfg_ready, cfg_index selects dead_zone (0) or
// max_value (1), cfg_data is the new value; other indexes are dropped.
// cfg_ready is always high; write only while no request is in flight.
// From input accept to output valid a request passes three front stages
// (magnitude, squares, sum), 24 square-root stages one root bit each, one
// range stage, 15 stages for the scale factor one quotient bit each, two
// stages for the product, 17 stages for the component divide and the output
// register. Throughput is one request per cycle while the pipeline is not held.
// Reset clears every stage valid bit and loads dead_zone 8000, max_value
// 30000. When out_ready is low with a result waiting, the whole pipeline
// holds and in_ready drops; nothing is lost or repeated.
module stick_radial_dead_zone_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  srdz_pkg::sample_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output srdz_pkg::result_t                   out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [srdz_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [srdz_pkg::REG_BITS-1:0]       cfg_data
);
  import srdz_pkg::*;

  localparam logic [CQ_STAGES-1:0] FULL_Q = CQ_STAGES'(1) << FRAC_BITS;

  logic [REG_BITS-1:0] dead_zone;
  logic [REG_BITS-1:0] max_value;
  logic                en;

  assign en        = out_ready || !out_valid;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_zone <= DEAD_ZONE_RESET;
      max_value <= MAX_VALUE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEAD_ZONE: dead_zone <= cfg_data;
        REG_MAX_VALUE: max_value <= cfg_data;
        default: ;
      endcase
    end
  end

  logic                a_vld, b_vld, c_vld;
  side_t               a_side, b_side, c_side;
  logic [SQ_BITS-1:0]  b_sqx, b_sqy, b_dz2, c_sum;
  side_t               a_side_next;

  always_comb begin
    a_side_next.nx   = in_data.stick_x[SAMPLE_BITS-1];
    a_side_next.ny   = in_data.stick_y[SAMPLE_BITS-1];
    a_side_next.ax   = a_side_next.nx ? MAG_BITS'(-in_data.stick_x) : MAG_BITS'(in_data.stick_x);
    a_side_next.ay   = a_side_next.ny ? MAG_BITS'(-in_data.stick_y) : MAG_BITS'(in_data.stick_y);
    a_side_next.dead = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_valid;
      b_vld <= a_vld;
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_side <= a_side_next;
      b_side <= a_side;
      b_sqx  <= a_side.ax * a_side.ax;
      b_sqy  <= a_side.ay * a_side.ay;
      b_dz2  <= dead_zone * dead_zone;
      c_side <= '{nx: b_side.nx, ny: b_side.ny, ax: b_side.ax, ay: b_side.ay,
                  dead: ((b_sqx + b_sqy) < b_dz2)};
      c_sum  <= b_sqx + b_sqy;
    end
  end

  logic                s_vld;
  side_t               s_side;
  logic [LEN_BITS-1:0] s_len;

  srdz_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (c_vld),
    .in_side  (c_side),
    .in_sq    (c_sum),
    .out_vld  (s_vld),
    .out_side (s_side),
    .out_len  (s_len)
  );

  logic                d_vld;
  side_t               d_side;
  logic [LEN_BITS-1:0] d_len, d_num, d_den;
  logic                d_full;
  logic [LEN_BITS-1:0] dzq, mvq;

  assign dzq = LEN_BITS'(dead_zone) << LEN_FRAC;
  assign mvq = LEN_BITS'(max_value) << LEN_FRAC;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else if (en) begin
      d_vld <= s_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_side <= s_side;
      d_len  <= s_len;
      d_full <= (max_value <= dead_zone) || (s_len >= mvq);
      d_num  <= (s_len > dzq) ? s_len - dzq : '0;
      d_den  <= mvq - dzq;
    end
  end

  logic                 f_vld;
  side_t                f_side;
  logic [LEN_BITS-1:0]  f_len;
  logic                 f_full;
  logic [FRAC_BITS-1:0] f_quo;

  srdz_fdiv u_fdiv (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (d_vld),
    .in_side  (d_side),
    .in_len   (d_len),
    .in_full  (d_full),
    .in_num   (d_num),
    .in_den   (d_den),
    .out_vld  (f_vld),
    .out_side (f_side),
    .out_len  (f_len),
    .out_full (f_full),
    .out_quo  (f_quo)
  );

  logic                 e_vld, g_vld;
  side_t                e_side, g_side;
  logic [LEN_BITS-1:0]  e_len, g_len;
  logic [PROD_BITS-1:0] e_px, e_py;
  logic [DVD_BITS-1:0]  g_dx, g_dy;
  logic [FQ_BITS-1:0]   fq;

  assign fq = f_full ? FQ_BITS'(1) << FRAC_BITS : {1'b0, f_quo};

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
      g_vld <= 1'b0;
    end else if (en) begin
      e_vld <= f_vld;
      g_vld <= e_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_side <= f_side;
      e_len  <= f_len;
      e_px   <= f_side.ax * fq;
      e_py   <= f_side.ay * fq;
      g_side <= e_side;
      g_len  <= e_len;
      g_dx   <= (DVD_BITS'(e_px) << LEN_FRAC) + DVD_BITS'(e_len >> 1);
      g_dy   <= (DVD_BITS'(e_py) << LEN_FRAC) + DVD_BITS'(e_len >> 1);
    end
  end

  logic                 q_vld;
  side_t                q_side;
  logic [LEN_BITS-1:0]  q_len;
  logic [CQ_STAGES-1:0] q_x, q_y;

  srdz_cdiv u_cdiv (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (g_vld),
    .in_side  (g_side),
    .in_len   (g_len),
    .in_dx    (g_dx),
    .in_dy    (g_dy),
    .out_vld  (q_vld),
    .out_side (q_side),
    .out_len  (q_len),
    .out_qx   (q_x),
    .out_qy   (q_y)
  );

  function automatic logic [OUT_BITS-1:0] finish(input logic neg,
                                                 input logic [CQ_STAGES-1:0] q);
    logic [CQ_STAGES-1:0] m;
    m = (q > FULL_Q) ? FULL_Q : q;
    if (!neg) begin
      if (m > FULL_Q - 1'b1) m = FULL_Q - 1'b1;
      return m[OUT_BITS-1:0];
    end
    return OUT_BITS'(-m);
  endfunction

  result_t res_next;

  always_comb begin
    res_next.in_dead_zone = q_side.dead;
    if (q_side.dead || q_len == '0) begin
      res_next.out_x = '0;
      res_next.out_y = '0;
    end else begin
      res_next.out_x = finish(q_side.nx, q_x);
      res_next.out_y = finish(q_side.ny, q_y);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= q_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= res_next;
    end
  end

endmodule

>>> test/stick_radial_dead_zone_core_tb.sv
module stick_radial_dead_zone_core_tb;
  import srdz_pkg::*;

  localparam int LATENCY = 63;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  sample_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  result_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [REG_BITS-1:0] cfg_data = '0;

  sample_t pending_samples[$];
  result_t expected_results[$];
  logic [REG_BITS-1:0] dz_reg = DEAD_ZONE_RESET;
  logic [REG_BITS-1:0] mv_reg = MAX_VALUE_RESET;
  int mismatches = 0;
  bit driver_on = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_phase = 0;

  stick_radial_dead_zone_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [OUT_BITS-1:0] scale_axis(input logic neg,
      input logic [63:0] mag, input logic [63:0] fq, input logic [63:0] lq);
    logic [63:0] m;
    logic [63:0] full;
    full = 64'd1 << FRAC_BITS;
    m = (((mag * fq) << LEN_FRAC) + (lq >> 1)) / lq;
    if (m > full) m = full;
    if (!neg) begin
      if (m > full - 1) m = full - 1;
      return m[OUT_BITS-1:0];
    end
    return OUT_BITS'(64'd0 - m);
  endfunction

  function automatic result_t dead_zone_scale(input sample_t s);
    result_t r;
    logic [63:0] ax, ay, sq, lq, fq, dzq, num, den, full;
    logic nx, ny;
    full = 64'd1 << FRAC_BITS;
    nx = s.stick_x[SAMPLE_BITS-1];
    ny = s.stick_y[SAMPLE_BITS-1];
    ax = nx ? -64'(s.stick_x) : 64'(s.stick_x);
    ay = ny ? -64'(s.stick_y) : 64'(s.stick_y);
    sq = ax * ax + ay * ay;
    r = '0;
    if (sq < 64'(dz_reg) * 64'(dz_reg)) begin
      r.in_dead_zone = 1'b1;
      return r;
    end
    lq = root64(sq << (2 * LEN_FRAC));
    if (lq == 0) return r;
    if (mv_reg <= dz_reg || lq >= (64'(mv_reg) << LEN_FRAC)) begin
      fq = full;
    end else begin
      dzq = 64'(dz_reg) << LEN_FRAC;
      num = lq > dzq ? lq - dzq : 0;
      den = 64'(mv_reg - dz_reg) << LEN_FRAC;
      fq = (num << FRAC_BITS) / den;
      if (fq > full) fq = full;
    end
    r.out_x = scale_axis(nx, ax, fq, lq);
    r.out_y = scale_axis(ny, ay, fq, lq);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst && driver_on) begin
      if (in_valid && in_ready) begin
        expected_results.push_back(dead_zone_scale(in_data));
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          in_data <= pending_samples.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      stall_phase <= (stall_phase + 1) % 96;
      out_ready <= (stall_phase < 40) ? 1'b1 :
                   (stall_phase < 70) ? ($urandom_range(0, 2) != 0) :
                   ($urandom_range(0, 4) == 0);
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_data);
        end else begin
          result_t e;
          e = expected_results.pop_front();
          if (e.out_x !== out_data.out_x || e.out_y !== out_data.out_y ||
              e.in_dead_zone !== out_data.in_dead_zone) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %0d %0d %0b actual %0d %0d %0b",
                       e.out_x, e.out_y, e.in_dead_zone,
                       out_data.out_x, out_data.out_y, out_data.in_dead_zone);
          end
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [REG_BITS-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_DEAD_ZONE) dz_reg = val;
    else if (idx == REG_MAX_VALUE) mv_reg = val;
  endtask

  task automatic drain_pipe();
    while (pending_samples.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic sample_t pick_sample();
    sample_t s;
    int k;
    k = $urandom_range(0, 9);
    s.stick_x = SAMPLE_BITS'($urandom);
    s.stick_y = SAMPLE_BITS'($urandom);
    if (k < 2) begin
      s.stick_x = SAMPLE_BITS'($signed($urandom_range(0, 2 * (dz_reg + 50))) - dz_reg - 50);
      s.stick_y = SAMPLE_BITS'($signed($urandom_range(0, 2 * (dz_reg + 50))) - dz_reg - 50);
    end else if (k == 2) begin
      s.stick_x = ($urandom_range(0, 1)) ? 16'sh8000 : 16'sh7fff;
    end
    return s;
  endfunction

  task automatic run_phase(input logic [REG_BITS-1:0] dz, input logic [REG_BITS-1:0] mv,
                           input int count);
    sample_t s;
    write_reg(REG_DEAD_ZONE, dz);
    write_reg(REG_MAX_VALUE, mv);
    write_reg(REG_SPARE, REG_BITS'($urandom));
    for (int i = 0; i < count; i++) begin
      s = pick_sample();
      pending_samples.push_back(s);
    end
    drain_pipe();
  endtask

  initial begin
    sample_t s;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    driver_on = 1'b1;
    s.stick_x = 0; s.stick_y = 0; pending_samples.push_back(s);
    s.stick_x = 16'sh7fff; s.stick_y = 0; pending_samples.push_back(s);
    s.stick_x = 16'sh8000; s.stick_y = 0; pending_samples.push_back(s);
    s.stick_x = 0; s.stick_y = 16'sh8000; pending_samples.push_back(s);
    s.stick_x = 16'sh8000; s.stick_y = 16'sh8000; pending_samples.push_back(s);
    s.stick_x = 16'sh7fff; s.stick_y = 16'sh7fff; pending_samples.push_back(s);
    s.stick_x = 7999; s.stick_y = 0; pending_samples.push_back(s);
    s.stick_x = 8000; s.stick_y = 0; pending_samples.push_back(s);
    s.stick_x = -4800; s.stick_y = 6400; pending_samples.push_back(s);
    s.stick_x = 30000; s.stick_y = 0; pending_samples.push_back(s);
    s.stick_x = 19000; s.stick_y = -1; pending_samples.push_back(s);
    drain_pipe();
    write_reg(REG_DEAD_ZONE, 0);
    s.stick_x = 0; s.stick_y = 0; pending_samples.push_back(s);
    s.stick_x = 1; s.stick_y = -1; pending_samples.push_back(s);
    drain_pipe();
    run_phase(8000, 30000, 350);
    run_phase(0, 0, 200);
    run_phase(16'd46341, 16'd46341, 150);
    run_phase(0, 16'd46341, 250);
    run_phase(20000, 5000, 150);
    run_phase(16'hffff, 16'hffff, 50);
    run_phase(100, 200, 200);
    run_phase(16'h8000, 16'h7fff, 50);
    for (int p = 0; p < 4; p++)
      run_phase(REG_BITS'($urandom_range(0, 46341)), REG_BITS'($urandom_range(0, 46341)), 60);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

>>> stick_radial_dead_zone_core.f
src/srdz_pkg.sv
src/srdz_sqrt.sv
src/srdz_fdiv.sv
src/srdz_cdiv.sv
src/stick_radial_dead_zone_core.sv
test/stick_radial_dead_zone_core_tb.sv
